// ----- src/wpsp_pkg.sv -----
// shared types and constants of the wav pcm16 mono stream parser
`default_nettype none

package wpsp_pkg;

    // chunk tags as they appear in the byte stream, first byte highest
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // header sizes in bytes
    localparam int unsigned MIN_FILE_BYTES = 44;
    localparam int unsigned FMT_MIN_BYTES  = 16;
    localparam int unsigned FMT_BITS_OFS   = 14;

    // verdict status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_HDR   = 3'd1;
    localparam logic [2:0] ST_TRUNC     = 3'd2;
    localparam logic [2:0] ST_ZERO      = 3'd3;
    localparam logic [2:0] ST_UNSUPPORT = 3'd4;

    // result beat packing
    localparam int unsigned TDATA_W = 88;

    // event queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    // parser phases
    typedef enum logic [2:0] {
        PH_FILE,
        PH_HEAD,
        PH_BODY,
        PH_PAD,
        PH_STOP
    } phase_t;

    // kind of the chunk being walked
    typedef enum logic [1:0] {
        CL_OTHER,
        CL_FMT,
        CL_DATA
    } cls_t;

    // results caused by one input byte: a sample, a verdict, or both
    typedef struct packed {
        logic        has_smp;
        logic [15:0] smp;
        logic        cs;
        logic        has_vrd;
        logic [2:0]  status;
        logic [30:0] rate;
        logic [30:0] cnt;
    } ev_t;

endpackage

`default_nettype wire

// ----- src/wpsp_front.sv -----
// byte parser: walks the riff chunks and produces sample and verdict events
`default_nettype none

module wpsp_front
    import wpsp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_data,
    input  wire logic       in_last,
    output logic            in_ready,
    output logic            ev_valid,
    output ev_t             ev,
    input  wire logic       ev_ready
);

    phase_t      phase_reg, phase_next;
    cls_t        class_reg, class_next;
    logic [5:0]  pos_reg, pos_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] off_reg, off_next;
    logic [2:0]  hidx_reg, hidx_next;
    logic [15:0] fmt_reg, fmt_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic        have_fmt_reg, have_fmt_next;
    logic        have_data_reg, have_data_next;
    logic [31:0] dlen_reg, dlen_next;
    logic [7:0]  held_reg, held_next;
    logic        first_reg, first_next;
    logic [2:0]  err_reg, err_next;

    logic        accept;
    logic        fmt_cap;
    logic [31:0] off_inc;
    logic [2:0]  verdict;
    logic        cut;

    assign in_ready = ev_ready;
    assign accept   = in_valid && ev_ready;
    assign fmt_cap  = (class_reg == CL_FMT) && (len_reg[31:4] != 28'd0);
    assign off_inc  = off_reg + 32'd1;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_FILE;
            class_reg     <= CL_OTHER;
            pos_reg       <= '0;
            tag_reg       <= '0;
            len_reg       <= '0;
            off_reg       <= '0;
            hidx_reg      <= '0;
            fmt_reg       <= '0;
            chan_reg      <= '0;
            rate_reg      <= '0;
            bits_reg      <= '0;
            have_fmt_reg  <= 1'b0;
            have_data_reg <= 1'b0;
            dlen_reg      <= '0;
            held_reg      <= '0;
            first_reg     <= 1'b0;
            err_reg       <= ST_OK;
        end else begin
            phase_reg     <= phase_next;
            class_reg     <= class_next;
            pos_reg       <= pos_next;
            tag_reg       <= tag_next;
            len_reg       <= len_next;
            off_reg       <= off_next;
            hidx_reg      <= hidx_next;
            fmt_reg       <= fmt_next;
            chan_reg      <= chan_next;
            rate_reg      <= rate_next;
            bits_reg      <= bits_next;
            have_fmt_reg  <= have_fmt_next;
            have_data_reg <= have_data_next;
            dlen_reg      <= dlen_next;
            held_reg      <= held_next;
            first_reg     <= first_next;
            err_reg       <= err_next;
        end
    end

    // next state, events and verdict
    always_comb begin
        phase_next     = phase_reg;
        class_next     = class_reg;
        pos_next       = pos_reg;
        tag_next       = tag_reg;
        len_next       = len_reg;
        off_next       = off_reg;
        hidx_next      = hidx_reg;
        fmt_next       = fmt_reg;
        chan_next      = chan_reg;
        rate_next      = rate_reg;
        bits_next      = bits_reg;
        have_fmt_next  = have_fmt_reg;
        have_data_next = have_data_reg;
        dlen_next      = dlen_reg;
        held_next      = held_reg;
        first_next     = first_reg;
        err_next       = err_reg;
        ev             = '0;
        verdict        = ST_OK;
        cut            = 1'b0;

        if (accept) begin
            // byte position saturates at 63, above the minimum header size
            if (pos_reg != 6'h3F) pos_next = pos_reg + 6'd1;

            unique case (phase_reg)
                PH_FILE: begin
                    if (pos_reg < 6'd4 || (pos_reg >= 6'd8 && pos_reg < 6'd12)) begin
                        tag_next = {tag_reg[23:0], in_data};
                    end
                    if (pos_reg == 6'd3) begin
                        if (tag_next != TAG_RIFF) begin
                            err_next   = ST_BAD_HDR;
                            phase_next = PH_STOP;
                        end
                        tag_next = '0;
                    end else if (pos_reg == 6'd11) begin
                        if (tag_next != TAG_WAVE) begin
                            err_next   = ST_BAD_HDR;
                            phase_next = PH_STOP;
                        end else begin
                            phase_next = PH_HEAD;
                            hidx_next  = '0;
                            tag_next   = '0;
                            len_next   = '0;
                        end
                    end
                end
                PH_HEAD: begin
                    // four tag bytes, then a little-endian length
                    if (!hidx_reg[2]) begin
                        tag_next = {tag_reg[23:0], in_data};
                    end else begin
                        case (hidx_reg[1:0])
                            2'd0:    len_next[7:0]   = in_data;
                            2'd1:    len_next[15:8]  = in_data;
                            2'd2:    len_next[23:16] = in_data;
                            default: len_next[31:24] = in_data;
                        endcase
                    end
                    hidx_next = hidx_reg + 3'd1;
                    if (hidx_reg == 3'd7) begin
                        class_next = (tag_reg == TAG_DATA) ? CL_DATA :
                                     (tag_reg == TAG_FMT)  ? CL_FMT  : CL_OTHER;
                        if (len_next == 32'd0) begin
                            err_next   = ST_ZERO;
                            phase_next = PH_STOP;
                        end else begin
                            phase_next = PH_BODY;
                            off_next   = '0;
                            if (tag_reg == TAG_DATA) begin
                                have_data_next = 1'b1;
                                dlen_next      = '0;
                                first_next     = 1'b1;
                            end else if (tag_reg == TAG_FMT &&
                                         len_next >= 32'(FMT_MIN_BYTES)) begin
                                have_fmt_next = 1'b1;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    // fmt fields from the first sixteen body bytes
                    if (fmt_cap && off_reg[31:4] == 28'd0) begin
                        case (off_reg[3:0])
                            4'd0:  fmt_next[7:0]    = in_data;
                            4'd1:  fmt_next[15:8]   = in_data;
                            4'd2:  chan_next[7:0]   = in_data;
                            4'd3:  chan_next[15:8]  = in_data;
                            4'd4:  rate_next[7:0]   = in_data;
                            4'd5:  rate_next[15:8]  = in_data;
                            4'd6:  rate_next[23:16] = in_data;
                            4'd7:  rate_next[31:24] = in_data;
                            4'd14: bits_next[7:0]   = in_data;
                            4'd15: bits_next[15:8]  = in_data;
                            default: ;
                        endcase
                    end else if (class_reg == CL_DATA) begin
                        // sample assembly, high byte completes a sample
                        if (dlen_reg != 32'hFFFF_FFFF) dlen_next = dlen_reg + 32'd1;
                        if (!off_reg[0]) begin
                            held_next = in_data;
                        end else begin
                            ev.has_smp = 1'b1;
                            ev.smp     = {in_data, held_reg};
                            ev.cs      = first_reg;
                            first_next = 1'b0;
                        end
                    end
                    off_next = off_inc;
                    if (off_inc == len_reg) begin
                        if (len_reg[0]) begin
                            phase_next = PH_PAD;
                        end else begin
                            phase_next = PH_HEAD;
                            hidx_next  = '0;
                            tag_next   = '0;
                            len_next   = '0;
                        end
                    end
                end
                PH_PAD: begin
                    phase_next = PH_HEAD;
                    hidx_next  = '0;
                    tag_next   = '0;
                    len_next   = '0;
                end
                PH_STOP: ;
                default: ;
            endcase

            // verdict on the final byte, then back to the reset state
            if (in_last) begin
                cut = (phase_next == PH_BODY);
                if (pos_next < 6'(MIN_FILE_BYTES)) begin
                    verdict = ST_BAD_HDR;
                end else if (err_next != ST_OK) begin
                    verdict = err_next;
                end else if (cut && class_next != CL_DATA) begin
                    verdict = ST_TRUNC;
                end else if (cut && dlen_next == 32'd0) begin
                    verdict = ST_ZERO;
                end else if (!have_fmt_next || !have_data_next || fmt_next != 16'd1 ||
                             chan_next != 16'd1 || bits_next != 16'd16 ||
                             rate_next == 32'd0 || rate_next[31] || dlen_next[0]) begin
                    verdict = ST_UNSUPPORT;
                end else begin
                    verdict = ST_OK;
                end
                ev.has_vrd = 1'b1;
                ev.status  = verdict;
                ev.rate    = (verdict == ST_OK) ? rate_next[30:0] : 31'd0;
                ev.cnt     = (verdict == ST_OK) ? dlen_next[31:1] : 31'd0;

                phase_next     = PH_FILE;
                class_next     = CL_OTHER;
                pos_next       = '0;
                tag_next       = '0;
                len_next       = '0;
                off_next       = '0;
                hidx_next      = '0;
                fmt_next       = '0;
                chan_next      = '0;
                rate_next      = '0;
                bits_next      = '0;
                have_fmt_next  = 1'b0;
                have_data_next = 1'b0;
                dlen_next      = '0;
                held_next      = '0;
                first_next     = 1'b0;
                err_next       = ST_OK;
            end
        end

        ev_valid = accept && (ev.has_smp || ev.has_vrd);
    end

endmodule

`default_nettype wire

// ----- src/wpsp_queue.sv -----
// short event queue that decouples the parser from the result port
`default_nettype none

module wpsp_queue
    import wpsp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  ev_t       push_data,
    output logic      not_full,
    output logic      q_valid,
    output ev_t       q_data,
    input  wire logic pop
);

    ev_t            mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign not_full = (count_reg != QCW'(QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_data   = mem_reg[rd_ptr_reg];
    assign do_push  = push && not_full;
    assign do_pop   = pop && q_valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCW'(QDEPTH))
        else $error("event queue over its depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("event queue lost a push");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> not_full)
        else $error("parser pushed into a full event queue");

endmodule

`default_nettype wire

// ----- src/wpsp_back.sv -----
// result stage: turns queued events into result beats, one beat per cycle while m_ready is high
`default_nettype none

module wpsp_back
    import wpsp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         q_valid,
    input  ev_t               q_data,
    output logic              q_pop,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [TDATA_W-1:0] m_data,
    output logic              m_user,
    output logic              m_last
);

    ev_t  cur_reg, cur_next;
    logic out_valid_reg, out_valid_next;
    logic smp_done_reg, smp_done_next;
    logic smp_beat;
    logic beat_done;
    logic entry_done;
    logic load;

    assign smp_beat   = cur_reg.has_smp && !smp_done_reg;
    assign beat_done  = out_valid_reg && m_ready;
    assign entry_done = beat_done && !(smp_beat && cur_reg.has_vrd);
    assign load       = q_valid && (!out_valid_reg || entry_done);
    assign q_pop      = load;

    // output register control
    always_comb begin
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        smp_done_next  = smp_done_reg;
        if (load) begin
            cur_next       = q_data;
            out_valid_next = 1'b1;
            smp_done_next  = 1'b0;
        end else if (entry_done) begin
            out_valid_next = 1'b0;
        end else if (beat_done) begin
            smp_done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            smp_done_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            smp_done_reg  <= smp_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    // beat formatting
    always_comb begin
        m_data = '0;
        if (smp_beat) begin
            m_data[15:0] = cur_reg.smp;
            m_data[16]   = cur_reg.cs;
        end else begin
            m_data[19:17] = cur_reg.status;
            m_data[50:20] = cur_reg.rate;
            m_data[81:51] = cur_reg.cnt;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_user  = !smp_beat;
    assign m_last  = !smp_beat;

endmodule

`default_nettype wire

// ----- src/wav_pcm16_mono_stream_parser.sv -----
// top level of the wav pcm16 mono stream parser
//
// input channel s_*: one byte of a wav file per beat, s_tlast on the last byte.
// result channel m_*: sample beats (m_tuser 0) carry a 16-bit little-endian
// pcm sample and a chunk start flag; the first sample of every data chunk has
// it set, so a consumer keeps only the samples after the last such flag.
// the verdict beat (m_tuser 1, m_tlast 1) ends each file with a status and,
// when the status is ok, the sample rate and sample count; on any other
// status the consumer drops the samples of that file.
// each result passes through the event queue and then the output register.
// throughput: one byte per cycle while the event queue has room; the result
// port moves one beat per cycle while m_tready is high, and the final byte
// may cause two beats, a sample and a verdict.
// a four entry event queue sits between the parser and the output register,
// so a stalled receiver fills the queue and s_tready drops only when it is
// full; no beat is lost or repeated.
// reset: aresetn low clears the parser to the start of a file and empties
// the queue and output register.
`default_nettype none

module wav_pcm16_mono_stream_parser
    import wpsp_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // data_byte
    input  wire logic               s_tlast,   // final_byte
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // sample[15:0], chunk_start[16], status[19:17], rate[50:20],
    // sample_count[81:51], zero fill[87:82]
    output logic [TDATA_W-1:0]      m_tdata,
    output logic                    m_tuser,   // result_kind
    output logic                    m_tlast    // end_mark
);

    ev_t  ev;
    ev_t  q_data;
    logic ev_valid;
    logic not_full;
    logic q_valid;
    logic q_pop;

    // parser front end
    wpsp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .ev_valid (ev_valid),
        .ev       (ev),
        .ev_ready (not_full)
    );

    // event queue
    wpsp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (ev_valid),
        .push_data (ev),
        .not_full  (not_full),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (q_pop)
    );

    // result back end
    wpsp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata),
        .m_user  (m_tuser),
        .m_last  (m_tlast)
    );

endmodule

`default_nettype wire
